// ===== rtl/core/first_fit_slot_allocator_top_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFSA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffsa: check failed");

// next-cycle implication
`define FFSA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffsa: check failed");

`endif

// ===== rtl/core/ffsa_pkg.sv =====
// Shared constants, types and codes for the first-fit slot allocator.
// No dependencies; imported by ffsa_cell and the top module.
package ffsa_pkg;

  localparam int SLOTS       = 1024;
  localparam int VALUE_BITS  = 30;
  localparam int AMOUNT_BITS = 30;
  localparam int SLOT_BITS   = 10;
  localparam int COUNT_BITS  = 32;
  localparam int LEVELS      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_BITS    = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int LOAD_BITS   = $clog2(SLOTS + 1);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [LEVELS-1:0]     idx_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  // one row of a level: both children of one parent
  typedef struct packed {
    val_t right;
    val_t left;
  } pair_t;

  // descent token, moves one level per cycle
  typedef struct packed {
    logic valid;
    idx_t idx;     // node index at the level it enters
    idx_t tgt;     // forced path, consumed msb first
    val_t need;
    logic forced;  // follow tgt instead of the fit test
  } dn_tok_t;

  // ascent token, carries the new max of the node below
  typedef struct packed {
    logic valid;
    val_t value;
  } up_tok_t;

  typedef struct packed {
    logic  en;
    logic  we;
    row_t  addr;
    pair_t wdata;
  } ram_req_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PLACE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_CLIMB
  } fsm_state_t;

endpackage

// ===== rtl/core/ffsa_ram.sv =====
// Generic single-port RAM with registered read data, held when not read.
// No dependencies.
module ffsa_ram #(
  parameter int ADDR_BITS = 1,
  parameter int WIDTH     = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [0:(1 << ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/ffsa_cell.sv =====
// One tree level of the allocator: fit test on the way down, max refresh on the way up.
// Depends on ffsa_pkg; the level's row RAM sits outside and is driven through ram_req.
module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     clr,
  input  row_t     clr_addr,
  input  dn_tok_t  dn_in,
  output dn_tok_t  dn_out,
  input  up_tok_t  up_in,
  output up_tok_t  up_out,
  output ram_req_t ram_req,
  input  pair_t    ram_rdata
);

  dn_tok_t dn_q;
  logic    side;
  logic    go_right;
  val_t    sib;
  val_t    parent_max;

  // rdata holds this row from the descent until the next descent
  always_comb begin
    go_right = dn_q.forced ? dn_q.tgt[LEVELS-1] : (ram_rdata.left < dn_q.need);

    dn_out.valid  = dn_q.valid;
    dn_out.idx    = (dn_q.idx << 1) | idx_t'(go_right);
    dn_out.tgt    = dn_q.tgt << 1;
    dn_out.need   = dn_q.need;
    dn_out.forced = dn_q.forced;

    sib        = side ? ram_rdata.left : ram_rdata.right;
    parent_max = (up_in.value > sib) ? up_in.value : sib;

    ram_req.en    = clr || dn_in.valid || up_in.valid;
    ram_req.we    = clr || up_in.valid;
    ram_req.wdata = '0;
    priority if (clr) begin
      ram_req.addr = clr_addr;
    end else if (up_in.valid) begin
      ram_req.addr = dn_q.idx[ROW_BITS-1:0];
      if (side) begin
        ram_req.wdata.left  = ram_rdata.left;
        ram_req.wdata.right = up_in.value;
      end else begin
        ram_req.wdata.left  = up_in.value;
        ram_req.wdata.right = ram_rdata.right;
      end
    end else begin
      ram_req.addr = dn_in.idx[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_q.valid   <= 1'b0;
      up_out.valid <= 1'b0;
    end else begin
      dn_q.valid   <= dn_in.valid;
      up_out.valid <= up_in.valid;
    end
    if (dn_in.valid) begin
      dn_q.idx    <= dn_in.idx;
      dn_q.tgt    <= dn_in.tgt;
      dn_q.need   <= dn_in.need;
      dn_q.forced <= dn_in.forced;
    end
    if (dn_q.valid) begin
      side <= go_right;
    end
    up_out.value <= parent_max;
  end

endmodule

// ===== rtl/core/first_fit_slot_allocator_top.sv =====
// First-fit slot allocator. After reset the level RAMs are swept to zero with
// busy high. A load or a place that walks the tree raises busy until its result
// is out: it passes down through one cell per level and back up through the same
// cells, each level kept in its own row RAM with one access per cycle. busy drops
// with done, so a new walked transaction is not taken until the last one has
// returned its result. A rejected load or an unplaced item reports on the cycle
// after start without raising busy, so the next start is taken right away.
// done marks a one-cycle result and cannot be held off; take status, slot and
// unplaced_count while it is high.
// Depends on ffsa_pkg, ffsa_cell, ffsa_ram and the macros header.
`include "first_fit_slot_allocator_top_macros.svh"

module first_fit_slot_allocator_top
  import ffsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action,
  input  logic [AMOUNT_BITS-1:0] amount,
  output logic                   done,
  output logic [1:0]             status,
  output logic [SLOT_BITS-1:0]   slot,
  output logic [COUNT_BITS-1:0]  unplaced_count
);

  fsm_state_t state, state_next;

  row_t                  clr_addr;
  logic [LOAD_BITS-1:0]  loaded;
  logic [COUNT_BITS-1:0] miss;
  val_t                  root;
  val_t                  new_val;
  idx_t                  leaf;
  status_t               status_q;
  logic [SLOT_BITS-1:0]  slot_q;

  dn_tok_t  dn_chain [0:LEVELS];
  up_tok_t  up_chain [1:LEVELS+1];
  ram_req_t ram_reqs [1:LEVELS];
  pair_t    ram_rd   [1:LEVELS];

  logic accept;
  logic is_load;
  logic full;
  logic no_fit;
  val_t val;
  val_t need;

  always_comb begin
    val     = amount[VALUE_BITS-1:0];
    need    = (val == '0) ? val_t'(1) : val;
    accept  = start && (state == S_IDLE);
    is_load = (action_t'(action) == ACT_LOAD);
    full    = (loaded >= LOAD_BITS'(SLOTS));
    no_fit  = (root < need);

    state_next = state;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (accept && !(is_load ? full : no_fit)) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (dn_chain[LEVELS].valid) begin
          state_next = S_CLIMB;
        end
      end
      S_CLIMB: begin
        if (up_chain[1].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= S_CLEAR;
      clr_addr                <= '0;
      loaded                  <= '0;
      miss                    <= '0;
      root                    <= '0;
      done                    <= 1'b0;
      dn_chain[0].valid       <= 1'b0;
      up_chain[LEVELS+1].valid <= 1'b0;
    end else begin
      state                   <= state_next;
      done                    <= 1'b0;
      dn_chain[0].valid       <= 1'b0;
      up_chain[LEVELS+1].valid <= 1'b0;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + row_t'(1);
      end
      if (accept) begin
        if (is_load) begin
          if (full) begin
            done     <= 1'b1;
            status_q <= STAT_FULL;
            slot_q   <= '0;
          end else begin
            dn_chain[0].valid <= 1'b1;
            loaded            <= loaded + LOAD_BITS'(1);
          end
        end else if (no_fit) begin
          done     <= 1'b1;
          status_q <= STAT_MISS;
          slot_q   <= '0;
          if (miss != '1) begin
            miss <= miss + COUNT_BITS'(1);
          end
        end else begin
          dn_chain[0].valid <= 1'b1;
        end
      end
      if (dn_chain[LEVELS].valid) begin
        up_chain[LEVELS+1].valid <= 1'b1;
      end
      if (up_chain[1].valid) begin
        root     <= up_chain[1].value;
        done     <= 1'b1;
        status_q <= STAT_DONE;
        slot_q   <= SLOT_BITS'(leaf);
      end
    end
    // payload of the transaction entering the tree
    if (accept) begin
      dn_chain[0].idx    <= '0;
      dn_chain[0].tgt    <= loaded[LEVELS-1:0];
      dn_chain[0].need   <= need;
      dn_chain[0].forced <= is_load;
      new_val            <= is_load ? val : '0;
    end
    if (dn_chain[LEVELS].valid) begin
      leaf                     <= dn_chain[LEVELS].idx;
      up_chain[LEVELS+1].value <= new_val;
    end
  end

  for (genvar d = 1; d <= LEVELS; d++) begin : g_level
    localparam int AB = (d > 1) ? d - 1 : 1;

    ffsa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .clr       (state == S_CLEAR),
      .clr_addr  (clr_addr),
      .dn_in     (dn_chain[d-1]),
      .dn_out    (dn_chain[d]),
      .up_in     (up_chain[d+1]),
      .up_out    (up_chain[d]),
      .ram_req   (ram_reqs[d]),
      .ram_rdata (ram_rd[d])
    );

    ffsa_ram #(
      .ADDR_BITS (AB),
      .WIDTH     (2 * VALUE_BITS)
    ) u_ram (
      .clk   (clk),
      .en    (ram_reqs[d].en),
      .we    (ram_reqs[d].we),
      .addr  (ram_reqs[d].addr[AB-1:0]),
      .wdata (ram_reqs[d].wdata),
      .rdata (ram_rd[d])
    );
  end

  assign status         = status_q;
  assign slot           = slot_q;
  assign unplaced_count = miss;

  `FFSA_ASSERT_IMP(a_walk_exit, dn_chain[LEVELS].valid, state == S_WALK)
  `FFSA_ASSERT_IMP(a_climb_exit, up_chain[1].valid, state == S_CLIMB)
  `FFSA_ASSERT_IMP(a_done_idle, done && (status_q == STAT_DONE), state == S_IDLE)
  `FFSA_ASSERT_IMP(a_slot_zero, done && (status_q != STAT_DONE), slot_q == '0)
  `FFSA_ASSERT_NXT(a_miss_mono, 1'b1, miss >= $past(miss))

endmodule
